>>> sv/tcfe_pkg.sv
// Package: widths, symbol and register codes, frame types and digit-split helpers.
`timescale 1ns / 1ps

package tcfe_pkg;

    localparam int FRAME_LEN = 60;
    localparam int POS_W     = 6;
    localparam int SYM_W     = 2;
    localparam int MS_W      = 10;
    localparam int CFG_IDX_W = 2;

    localparam int YEAR_W   = 7;
    localparam int DAY_W    = 9;
    localparam int WDAY_W   = 3;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;

    // remainder after the weight-20 step is below 20
    localparam int REM_W = 5;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    typedef logic [FRAME_LEN-1:0] frame_bits_t;

    // marker positions 0, 9, 19, 29, 39, 49, 59
    localparam frame_bits_t MARK_MASK = 60'h802008020080201;

    typedef enum logic [SYM_W-1:0] {
        SYM_ZERO = 2'd0,
        SYM_ONE  = 2'd1,
        SYM_MARK = 2'd2
    } sym_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MARKER_ON = 2'd0,
        REG_ONE_ON    = 2'd1,
        REG_ZERO_ON   = 2'd2
    } cfg_reg_t;

    localparam logic [MS_W-1:0] MARKER_ON_RST = 10'd200;
    localparam logic [MS_W-1:0] ONE_ON_RST    = 10'd500;
    localparam logic [MS_W-1:0] ZERO_ON_RST   = 10'd800;

    // front -> queue
    typedef struct packed {
        logic        valid;
        frame_bits_t bits;
    } q_push_t;

    // queue -> back
    typedef struct packed {
        logic        avail;
        frame_bits_t bits;
    } q_head_t;

    // One greedy digit step: bit set if v holds w at least once, remainder
    // drops by the whole multiple (at most two for the field widths used).
    // Result is {bit, remainder}.
    function automatic logic [DAY_W:0] split_step(logic [DAY_W-1:0] v,
                                                  logic [DAY_W-1:0] w);
        logic [DAY_W:0] w2;
        logic [DAY_W:0] res;
        w2 = {w, 1'b0};
        if ({1'b0, v} >= w2)
            res = {1'b1, v - w2[DAY_W-1:0]};
        else if (v >= w)
            res = {1'b1, v - w};
        else
            res = {1'b0, v};
        return res;
    endfunction

    // Weights 10, 8, 4, 2, 1 on a remainder below 20; bit 4 is weight 10.
    function automatic logic [4:0] tail_split(logic [REM_W-1:0] v);
        logic [DAY_W:0]   s;
        logic [DAY_W-1:0] r;
        logic [4:0]       b;
        r    = DAY_W'(v);
        s    = split_step(r, 9'd10);
        b[4] = s[DAY_W];
        r    = s[DAY_W-1:0];
        s    = split_step(r, 9'd8);
        b[3] = s[DAY_W];
        r    = s[DAY_W-1:0];
        s    = split_step(r, 9'd4);
        b[2] = s[DAY_W];
        r    = s[DAY_W-1:0];
        s    = split_step(r, 9'd2);
        b[1] = s[DAY_W];
        r    = s[DAY_W-1:0];
        s    = split_step(r, 9'd1);
        b[0] = s[DAY_W];
        return b;
    endfunction

endpackage

>>> sv/tcfe_ifs.sv
// Interfaces: time-stamp input channel and symbol output channel.
`timescale 1ns / 1ps

interface tcfe_stamp_if;
    import tcfe_pkg::*;

    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   year_in_century;
    logic [DAY_W-1:0]    day_of_year;
    logic [WDAY_W-1:0]   weekday;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;

    modport source (output valid, year_in_century, day_of_year, weekday, hour, minute,
                    input ready);
    modport sink (input valid, year_in_century, day_of_year, weekday, hour, minute,
                  output ready);
endinterface

interface tcfe_sym_if;
    import tcfe_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;
    logic [SYM_W-1:0] symbol;
    logic [MS_W-1:0]  on_time_ms;
    logic             last;

    modport source (output valid, position, symbol, on_time_ms, last, input ready);
    modport sink (input valid, position, symbol, on_time_ms, last, output ready);
endinterface

>>> sv/tcfe_front.sv
// Front: two-stage pipeline that splits the time fields into frame bits.
`timescale 1ns / 1ps

module tcfe_front (
    input  logic               clk,
    input  logic               rst_n,
    tcfe_stamp_if.sink         stamp,
    input  logic               q_full,
    output tcfe_pkg::q_push_t  push
);
    import tcfe_pkg::*;

    // stage 1: raw fields
    logic                s1_valid_reg;
    logic [YEAR_W-1:0]   s1_year_reg;
    logic [DAY_W-1:0]    s1_day_reg;
    logic [WDAY_W-1:0]   s1_wday_reg;
    logic [HOUR_W-1:0]   s1_hour_reg;
    logic [MINUTE_W-1:0] s1_min_reg;

    // stage 2: high-weight bits and remainders
    logic              s2_valid_reg;
    logic [1:0]        s2_min_hi_reg;
    logic [REM_W-1:0]  s2_min_rem_reg;
    logic              s2_hour_hi_reg;
    logic [REM_W-1:0]  s2_hour_rem_reg;
    logic [4:0]        s2_day_hi_reg;
    logic [REM_W-1:0]  s2_day_rem_reg;
    logic [2:0]        s2_year_hi_reg;
    logic [REM_W-1:0]  s2_year_rem_reg;
    logic [WDAY_W-1:0] s2_wday_reg;

    logic s1_free, s1_adv, s2_free, s2_adv;

    logic [1:0]       min_hi;
    logic [REM_W-1:0] min_rem;
    logic             hour_hi;
    logic [REM_W-1:0] hour_rem;
    logic [4:0]       day_hi;
    logic [REM_W-1:0] day_rem;
    logic [2:0]       year_hi;
    logic [REM_W-1:0] year_rem;

    logic [6:0]  min_bits;
    logic [5:0]  hour_bits;
    logic [9:0]  day_bits;
    logic [7:0]  year_bits;
    frame_bits_t frame;

    assign s2_adv  = s2_valid_reg && !q_full;
    assign s2_free = !s2_valid_reg || s2_adv;
    assign s1_adv  = s1_valid_reg && s2_free;
    assign s1_free = !s1_valid_reg || s1_adv;

    assign stamp.ready = s1_free;

    // weights 200 down to 20
    always_comb
    begin
        logic [DAY_W:0]   s;
        logic [DAY_W-1:0] r;

        r          = DAY_W'(s1_min_reg);
        s          = split_step(r, 9'd40);
        min_hi[1]  = s[DAY_W];
        s          = split_step(s[DAY_W-1:0], 9'd20);
        min_hi[0]  = s[DAY_W];
        min_rem    = s[REM_W-1:0];

        r          = DAY_W'(s1_hour_reg);
        s          = split_step(r, 9'd20);
        hour_hi    = s[DAY_W];
        hour_rem   = s[REM_W-1:0];

        s          = split_step(s1_day_reg, 9'd200);
        day_hi[4]  = s[DAY_W];
        s          = split_step(s[DAY_W-1:0], 9'd100);
        day_hi[3]  = s[DAY_W];
        s          = split_step(s[DAY_W-1:0], 9'd80);
        day_hi[2]  = s[DAY_W];
        s          = split_step(s[DAY_W-1:0], 9'd40);
        day_hi[1]  = s[DAY_W];
        s          = split_step(s[DAY_W-1:0], 9'd20);
        day_hi[0]  = s[DAY_W];
        day_rem    = s[REM_W-1:0];

        r          = DAY_W'(s1_year_reg);
        s          = split_step(r, 9'd80);
        year_hi[2] = s[DAY_W];
        s          = split_step(s[DAY_W-1:0], 9'd40);
        year_hi[1] = s[DAY_W];
        s          = split_step(s[DAY_W-1:0], 9'd20);
        year_hi[0] = s[DAY_W];
        year_rem   = s[REM_W-1:0];
    end

    // weights 10 down to 1, then place bits in the frame
    always_comb
    begin
        min_bits  = {s2_min_hi_reg, tail_split(s2_min_rem_reg)};
        hour_bits = {s2_hour_hi_reg, tail_split(s2_hour_rem_reg)};
        day_bits  = {s2_day_hi_reg, tail_split(s2_day_rem_reg)};
        year_bits = {s2_year_hi_reg, tail_split(s2_year_rem_reg)};

        frame = '0;
        for (int k = 0; k < 3; k++)
        begin
            frame[1 + k]  = min_bits[6 - k];
            frame[5 + k]  = min_bits[3 - k];
            frame[16 + k] = hour_bits[2 - k];
            frame[30 + k] = day_bits[3 - k];
            frame[50 + k] = s2_wday_reg[2 - k];  // weights 4, 2, 1: plain binary
        end
        frame[8]  = min_bits[0];
        frame[12] = hour_bits[5];
        frame[13] = hour_bits[4];
        frame[15] = hour_bits[3];
        frame[22] = day_bits[9];
        frame[23] = day_bits[8];
        for (int k = 0; k < 4; k++)
            frame[25 + k] = day_bits[7 - k];
        frame[33] = day_bits[0];
        for (int k = 0; k < 8; k++)
            frame[41 + k] = year_bits[7 - k];
        frame[36] = ^hour_bits;
        frame[37] = ^min_bits;
    end

    assign push.valid = s2_adv;
    assign push.bits  = frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= stamp.valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stamp.valid && s1_free)
        begin
            s1_year_reg <= stamp.year_in_century;
            s1_day_reg  <= stamp.day_of_year;
            s1_wday_reg <= stamp.weekday;
            s1_hour_reg <= stamp.hour;
            s1_min_reg  <= stamp.minute;
        end
        if (s1_adv)
        begin
            s2_min_hi_reg   <= min_hi;
            s2_min_rem_reg  <= min_rem;
            s2_hour_hi_reg  <= hour_hi;
            s2_hour_rem_reg <= hour_rem;
            s2_day_hi_reg   <= day_hi;
            s2_day_rem_reg  <= day_rem;
            s2_year_hi_reg  <= year_hi;
            s2_year_rem_reg <= year_rem;
            s2_wday_reg     <= s1_wday_reg;
        end
    end

endmodule

>>> sv/tcfe_queue.sv
// Queue: two-entry FIFO of frame bit vectors between front and back.
`timescale 1ns / 1ps

module tcfe_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  tcfe_pkg::q_push_t  push,
    output logic               full,
    input  logic               pop,
    output tcfe_pkg::q_head_t  head
);
    import tcfe_pkg::*;

    frame_bits_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    logic do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.avail = (count_reg != 2'd0);
    assign head.bits  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.bits;
    end

endmodule

>>> sv/tcfe_back.sv
// Back: walks the head frame one position per item, holds the on-time registers.
`timescale 1ns / 1ps

module tcfe_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tcfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcfe_pkg::MS_W-1:0]       cfg_wdata,
    input  tcfe_pkg::q_head_t               head,
    output logic                            pop,
    tcfe_sym_if.source                      sym
);
    import tcfe_pkg::*;

    logic [MS_W-1:0]  marker_on_ms_reg;
    logic [MS_W-1:0]  one_on_ms_reg;
    logic [MS_W-1:0]  zero_on_ms_reg;

    logic [POS_W-1:0] pos_reg;
    logic             out_valid_reg;
    logic [POS_W-1:0] position_reg;
    logic [SYM_W-1:0] symbol_reg;
    logic [MS_W-1:0]  on_time_reg;
    logic             last_reg;

    logic             load;
    logic             at_last;
    sym_t             cur_sym;
    logic [MS_W-1:0]  cur_on;

    assign load    = head.avail && (!out_valid_reg || sym.ready);
    assign at_last = (pos_reg == LAST_POS);
    assign pop     = load && at_last;

    always_comb
    begin
        if (MARK_MASK[pos_reg])
            cur_sym = SYM_MARK;
        else if (head.bits[pos_reg])
            cur_sym = SYM_ONE;
        else
            cur_sym = SYM_ZERO;

        case (cur_sym)
            SYM_MARK: cur_on = marker_on_ms_reg;
            SYM_ONE:  cur_on = one_on_ms_reg;
            default:  cur_on = zero_on_ms_reg;
        endcase
    end

    assign sym.valid      = out_valid_reg;
    assign sym.position   = position_reg;
    assign sym.symbol     = symbol_reg;
    assign sym.on_time_ms = on_time_reg;
    assign sym.last       = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_on_ms_reg <= MARKER_ON_RST;
            one_on_ms_reg    <= ONE_ON_RST;
            zero_on_ms_reg   <= ZERO_ON_RST;
            pos_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MARKER_ON: marker_on_ms_reg <= cfg_wdata;
                    REG_ONE_ON:    one_on_ms_reg    <= cfg_wdata;
                    REG_ZERO_ON:   zero_on_ms_reg   <= cfg_wdata;
                    default:       ;
                endcase
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= at_last ? '0 : pos_reg + POS_W'(1);
            end
            else if (sym.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            position_reg <= pos_reg;
            symbol_reg   <= cur_sym;
            on_time_reg  <= cur_on;
            last_reg     <= at_last;
        end
    end

endmodule

>>> sv/time_code_frame_encoder.sv
// Top level: time-code frame encoder (minute fields in, 60 frame symbols out).
//
//  channel  dir  protocol        payload
//  stamp    in   valid/ready     year_in_century, day_of_year, weekday, hour, minute
//  sym      out  valid/ready     position, symbol, on_time_ms, last
//  cfg_*    in   write enable    cfg_index (0 marker, 1 one, 2 zero), cfg_wdata
//
// One stamp item yields 60 sym items, one per cycle while sym.ready is high;
// the back's position walk produces them. The queue holds two split frames,
// so the next stamp is taken while the current frame is still being sent.
// Reset clears the pipeline and queue and loads on-times 200/500/800 ms.
// A stall on sym holds the output register; the queue then fills and
// stamp.ready drops once front and queue are all occupied.
`timescale 1ns / 1ps

module time_code_frame_encoder (
    input  logic                            clk,
    input  logic                            rst_n,
    tcfe_stamp_if.sink                      stamp,
    tcfe_sym_if.source                      sym,
    input  logic                            cfg_we,
    input  logic [tcfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcfe_pkg::MS_W-1:0]       cfg_wdata
);
    import tcfe_pkg::*;

    q_push_t q_push;   // split frame leaving the front
    q_head_t q_head;   // oldest frame waiting for the back
    logic    q_full;
    logic    q_pop;    // back finished position 59

    // digit split of the time fields, two pipeline stages
    tcfe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .stamp  (stamp),
        .q_full (q_full),
        .push   (q_push)
    );

    tcfe_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .pop   (q_pop),
        .head  (q_head)
    );

    // symbol sequencer with output register and on-time registers
    tcfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .head      (q_head),
        .pop       (q_pop),
        .sym       (sym)
    );

endmodule

>>> sv/tcfe_checker.sv
// Checker: port-level properties of the encoder, bound to the top level.
`timescale 1ns / 1ps

module tcfe_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        sym_valid,
    input logic                        sym_ready,
    input logic [tcfe_pkg::POS_W-1:0]  sym_position,
    input logic [tcfe_pkg::SYM_W-1:0]  sym_symbol,
    input logic                        sym_last
);
    import tcfe_pkg::*;

    logic at_marker;
    assign at_marker = (sym_position == 6'd0) || (sym_position == 6'd9)
                    || (sym_position == 6'd19) || (sym_position == 6'd29)
                    || (sym_position == 6'd39) || (sym_position == 6'd49)
                    || (sym_position == 6'd59);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && !sym_ready |=> sym_valid && $stable(sym_position)
                                    && $stable(sym_symbol))
        else $error("output item changed while stalled");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid |-> (sym_last == (sym_position == LAST_POS)))
        else $error("last flag does not match final position");

    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid |-> ((sym_symbol == SYM_MARK) == at_marker))
        else $error("marker symbol at wrong position");

    a_walk: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && sym_ready && !sym_last
            |=> sym_valid && (sym_position == $past(sym_position) + 6'd1))
        else $error("frame positions not consecutive");

endmodule

bind time_code_frame_encoder tcfe_checker u_tcfe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sym_valid    (sym.valid),
    .sym_ready    (sym.ready),
    .sym_position (sym.position),
    .sym_symbol   (sym.symbol),
    .sym_last     (sym.last)
);

>>> tb/time_code_frame_encoder_test.sv
// Testbench: time-code frame encoder, frames checked symbol by symbol against a predictor.
`timescale 1ns / 1ps

module time_code_frame_encoder_test;
    import tcfe_pkg::*;

    // Run guard: the slowest legal run (about 210 frames, 60 symbols each, the
    // receiver stalling about three times in four) stays well under this limit.
    localparam int unsigned CYCLE_LIMIT = 400_000;
    // Quiet cycles before a register write and at the end; the front is two
    // stages deep, so this is generous.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_REPORTS = 10;

    // Register index with no register behind it; writes there are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [MS_W-1:0] MARKER_ON_DEFAULT = 10'd200;
    localparam logic [MS_W-1:0] ONE_ON_DEFAULT    = 10'd500;
    localparam logic [MS_W-1:0] ZERO_ON_DEFAULT   = 10'd800;

    // Digit weights, highest first; each field starts at the first weight
    // that fits its range.
    localparam int unsigned DIGIT_WEIGHT [10] = '{200, 100, 80, 40, 20, 10, 8, 4, 2, 1};
    localparam int MINUTE_FIRST = 3;
    localparam int HOUR_FIRST   = 4;
    localparam int DAY_FIRST    = 0;
    localparam int YEAR_FIRST   = 2;
    localparam int WDAY_FIRST   = 7;

    // Second slots of each field's digits, highest weight first.
    localparam int MARKER_SLOTS [7]  = '{0, 9, 19, 29, 39, 49, 59};
    localparam int MINUTE_SLOTS [7]  = '{1, 2, 3, 5, 6, 7, 8};
    localparam int HOUR_SLOTS   [6]  = '{12, 13, 15, 16, 17, 18};
    localparam int DAY_SLOTS    [10] = '{22, 23, 25, 26, 27, 28, 30, 31, 32, 33};
    localparam int YEAR_SLOTS   [8]  = '{41, 42, 43, 44, 45, 46, 47, 48};
    localparam int WDAY_SLOTS   [3]  = '{50, 51, 52};
    localparam int HOUR_PARITY_SLOT   = 36;
    localparam int MINUTE_PARITY_SLOT = 37;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [DAY_W-1:0]    day;
        logic [WDAY_W-1:0]   wday;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } stamp_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        sym_t             symbol;
        logic [MS_W-1:0]  on_ms;
        logic             last;
    } frame_symbol_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MS_W-1:0]      cfg_wdata;

    tcfe_stamp_if stamp_ch ();
    tcfe_sym_if   sym_ch ();

    time_code_frame_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .stamp     (stamp_ch),
        .sym       (sym_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor's copy of the on-time registers.
    logic [MS_W-1:0] marker_ms = MARKER_ON_DEFAULT;
    logic [MS_W-1:0] one_ms    = ONE_ON_DEFAULT;
    logic [MS_W-1:0] zero_ms   = ZERO_ON_DEFAULT;

    // Symbols still owed by the block, oldest first.
    frame_symbol_t symbols_due [$];

    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 0;   // chance per cycle the sender sits idle
    int unsigned recv_stall_pct = 0;  // chance per cycle the receiver stalls
    int unsigned hold_left     = 0;   // cycles left in a forced receiver hold-off

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Greedy split of v over the weights from index first on; digit k of the
    // result belongs to the k-th weight used. A weight held more than once
    // still gives a single set bit, and the whole multiple is taken away.
    function automatic logic [9:0] greedy_digits(input int unsigned v, input int first);
        logic [9:0]  d;
        int unsigned q;
        int          i;
        int          k;
        d = '0;
        k = 0;
        for (i = first; i < 10; i++)
        begin
            q    = v / DIGIT_WEIGHT[i];
            d[k] = (q != 0);
            v    = v - q * DIGIT_WEIGHT[i];
            k++;
        end
        return d;
    endfunction

    function automatic sym_t bit_symbol(input logic b);
        return b ? SYM_ONE : SYM_ZERO;
    endfunction

    // Build the whole 60-symbol frame for one stamp and queue it.
    function automatic void predict_frame(input stamp_t s);
        sym_t          frame [FRAME_LEN];
        logic [9:0]    min_d;
        logic [9:0]    hour_d;
        logic [9:0]    day_d;
        logic [9:0]    year_d;
        logic [9:0]    wday_d;
        frame_symbol_t fs;
        int            i;
        for (i = 0; i < FRAME_LEN; i++)
            frame[i] = SYM_ZERO;
        for (i = 0; i < 7; i++)
            frame[MARKER_SLOTS[i]] = SYM_MARK;

        min_d  = greedy_digits(s.minute, MINUTE_FIRST);
        hour_d = greedy_digits(s.hour, HOUR_FIRST);
        day_d  = greedy_digits(s.day, DAY_FIRST);
        year_d = greedy_digits(s.year, YEAR_FIRST);
        wday_d = greedy_digits(s.wday, WDAY_FIRST);

        for (i = 0; i < 7; i++)
            frame[MINUTE_SLOTS[i]] = bit_symbol(min_d[i]);
        for (i = 0; i < 6; i++)
            frame[HOUR_SLOTS[i]] = bit_symbol(hour_d[i]);
        for (i = 0; i < 10; i++)
            frame[DAY_SLOTS[i]] = bit_symbol(day_d[i]);
        for (i = 0; i < 8; i++)
            frame[YEAR_SLOTS[i]] = bit_symbol(year_d[i]);
        for (i = 0; i < 3; i++)
            frame[WDAY_SLOTS[i]] = bit_symbol(wday_d[i]);

        // Even parity: the slot is one when the digit bits hold an odd count.
        // Unused digit bits are zero, so a reduction over all ten is safe.
        frame[HOUR_PARITY_SLOT]   = bit_symbol(^hour_d);
        frame[MINUTE_PARITY_SLOT] = bit_symbol(^min_d);

        for (i = 0; i < FRAME_LEN; i++)
        begin
            fs.position = POS_W'(i);
            fs.symbol   = frame[i];
            case (frame[i])
                SYM_MARK: fs.on_ms = marker_ms;
                SYM_ONE:  fs.on_ms = one_ms;
                default:  fs.on_ms = zero_ms;
            endcase
            fs.last = (i == FRAME_LEN - 1);
            symbols_due.push_back(fs);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    // Every accepted symbol is matched against the oldest one owed. Values
    // are taken at the edge, before any nonblocking update lands.
    always @(posedge clk)
    begin
        frame_symbol_t want;
        if (rst_n && sym_ch.valid && sym_ch.ready)
        begin
            if (symbols_due.size() == 0)
                flag_error($sformatf("unexpected symbol: pos %0d sym %0d on %0d last %0b",
                                     sym_ch.position, sym_ch.symbol, sym_ch.on_time_ms,
                                     sym_ch.last));
            else
            begin
                want = symbols_due.pop_front();
                if (sym_ch.position !== want.position)
                    flag_error($sformatf("position: expected %0d, got %0d",
                                         want.position, sym_ch.position));
                if (sym_ch.symbol !== want.symbol)
                    flag_error($sformatf("symbol at pos %0d: expected %0d, got %0d",
                                         want.position, want.symbol, sym_ch.symbol));
                if (sym_ch.on_time_ms !== want.on_ms)
                    flag_error($sformatf("on_time_ms at pos %0d: expected %0d, got %0d",
                                         want.position, want.on_ms, sym_ch.on_time_ms));
                if (sym_ch.last !== want.last)
                    flag_error($sformatf("last at pos %0d: expected %0b, got %0b",
                                         want.position, want.last, sym_ch.last));
            end
        end
    end

    // Receiver: random stalls, or a forced hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            sym_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            sym_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hang guard.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[%0t] ERROR: timeout with %0d symbols outstanding",
                     $realtime, symbols_due.size());
            $display("** time_code_frame_encoder: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic stamp_t make_stamp(input int unsigned y, input int unsigned d,
                                          input int unsigned w, input int unsigned h,
                                          input int unsigned m);
        stamp_t s;
        s.year   = YEAR_W'(y);
        s.day    = DAY_W'(d);
        s.wday   = WDAY_W'(w);
        s.hour   = HOUR_W'(h);
        s.minute = MINUTE_W'(m);
        return s;
    endfunction

    // Mostly calendar-legal fields; one field in four spans its full width
    // so every bit, and the greedy overflow split, gets exercised.
    function automatic stamp_t random_stamp();
        stamp_t s;
        s.year   = ($urandom_range(3) == 0) ? YEAR_W'($urandom)   : YEAR_W'($urandom_range(99));
        s.day    = ($urandom_range(3) == 0) ? DAY_W'($urandom)    : DAY_W'($urandom_range(366));
        s.wday   = ($urandom_range(3) == 0) ? WDAY_W'($urandom)   : WDAY_W'($urandom_range(6));
        s.hour   = ($urandom_range(3) == 0) ? HOUR_W'($urandom)   : HOUR_W'($urandom_range(23));
        s.minute = ($urandom_range(3) == 0) ? MINUTE_W'($urandom) : MINUTE_W'($urandom_range(59));
        return s;
    endfunction

    function automatic logic [MS_W-1:0] random_on_time();
        case ($urandom_range(9))
            0:       return MS_W'(0);
            1:       return MS_W'(1000);
            2:       return MS_W'($urandom_range(1023, 1001));
            default: return MS_W'($urandom_range(1000));
        endcase
    endfunction

    // Offer one stamp, hold it until taken, then maybe leave a gap. Valid is
    // only lowered when a gap follows, so back-to-back items never see a
    // low/high pair in one time step.
    task automatic send_stamp(input stamp_t s);
        int unsigned gap;
        stamp_ch.valid           <= 1'b1;
        stamp_ch.year_in_century <= s.year;
        stamp_ch.day_of_year     <= s.day;
        stamp_ch.weekday         <= s.wday;
        stamp_ch.hour            <= s.hour;
        stamp_ch.minute          <= s.minute;
        @(posedge clk);
        while (!stamp_ch.ready)
            @(posedge clk);
        predict_frame(s);
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            stamp_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid, wait for every owed symbol, then a few quiet cycles.
    task automatic settle_idle();
        stamp_ch.valid <= 1'b0;
        @(posedge clk);
        while (symbols_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; only called once the block is idle.
    task automatic write_on_time(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MARKER_ON: marker_ms = value;
            REG_ONE_ON:    one_ms    = value;
            REG_ZERO_ON:   zero_ms   = value;
            default:       ;
        endcase
    endtask

    task automatic load_on_times(input logic [MS_W-1:0] mk, input logic [MS_W-1:0] one,
                                 input logic [MS_W-1:0] zero);
        settle_idle();
        write_on_time(REG_MARKER_ON, mk);
        write_on_time(REG_ONE_ON, one);
        write_on_time(REG_ZERO_ON, zero);
    endtask

    task automatic run_random_frames(input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
        int unsigned n;
        load_on_times(random_on_time(), random_on_time(), random_on_time());
        if ($urandom_range(1) == 0)
            write_on_time(REG_SPARE, random_on_time());
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (n = 0; n < count; n++)
            send_stamp(random_stamp());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset on-times with all-zero, calendar-max, full-width and striped fields.
    task automatic test_reset_on_times();
        send_stamp(make_stamp(0, 0, 0, 0, 0));
        send_stamp(make_stamp(99, 366, 6, 23, 59));
        send_stamp(make_stamp(127, 511, 7, 31, 63));
        send_stamp(make_stamp(85, 341, 5, 21, 42));
    endtask

    // Field extremes, greedy overflow and both parity senses.
    task automatic test_field_extremes();
        send_stamp(make_stamp(42, 170, 2, 10, 21));   // inverse stripes
        send_stamp(make_stamp(0, 400, 0, 0, 0));      // day holds 200 twice
        send_stamp(make_stamp(79, 199, 3, 19, 39));   // just below each top weight
        send_stamp(make_stamp(80, 300, 4, 20, 40));   // exactly each top weight; day is 200 + 100
        send_stamp(make_stamp(0, 0, 0, 1, 0));        // odd hour parity alone
        send_stamp(make_stamp(0, 0, 0, 0, 1));        // odd minute parity alone
        send_stamp(make_stamp(33, 33, 1, 3, 3));      // even parity, bits set
        send_stamp(make_stamp(100, 1, 0, 24, 60));    // out-of-range year, hour, minute
        send_stamp(make_stamp(120, 366, 7, 29, 59));
    endtask

    // Register extremes, pass-through above 1000 and the unused index.
    task automatic test_on_time_registers();
        load_on_times(MS_W'(0), MS_W'(0), MS_W'(0));
        send_stamp(make_stamp(99, 366, 6, 23, 59));
        load_on_times(MS_W'(1000), MS_W'(1000), MS_W'(1000));
        send_stamp(make_stamp(12, 123, 4, 15, 37));
        load_on_times(MS_W'(1023), MS_W'(1001), MS_W'(1023));
        send_stamp(make_stamp(127, 511, 7, 31, 63));
        load_on_times(MS_W'(1), MS_W'(1000), MS_W'(0));
        settle_idle();
        write_on_time(REG_SPARE, MS_W'(777));         // must leave all three alone
        send_stamp(make_stamp(85, 341, 5, 21, 42));
        send_stamp(make_stamp(0, 0, 0, 0, 0));
    endtask

    task automatic test_random_free_flow();
        run_random_frames(45, 0, 0);
    endtask

    task automatic test_random_sender_gaps();
        run_random_frames(45, 74, 0);
    endtask

    task automatic test_random_receiver_stalls();
        run_random_frames(45, 0, 74);
    endtask

    task automatic test_random_mixed_gaps();
        run_random_frames(35, 25, 25);
    endtask

    // Long receiver hold-off while the sender keeps offering: the frame
    // queue fills and stamp.ready must drop. Then the sender waits for a
    // full drain before the second burst.
    task automatic test_output_backpressure();
        int unsigned n;
        load_on_times(random_on_time(), random_on_time(), random_on_time());
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 400;
        for (n = 0; n < 12; n++)
            send_stamp(random_stamp());
        settle_idle();
        recv_stall_pct = 50;
        for (n = 0; n < 8; n++)
            send_stamp(random_stamp());
    endtask

    initial
    begin
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = '0;
        cfg_wdata                = '0;
        stamp_ch.valid           = 1'b0;
        stamp_ch.year_in_century = '0;
        stamp_ch.day_of_year     = '0;
        stamp_ch.weekday         = '0;
        stamp_ch.hour            = '0;
        stamp_ch.minute          = '0;
        sym_ch.ready             = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_on_times();
        test_field_extremes();
        test_on_time_registers();
        test_random_free_flow();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_mixed_gaps();
        test_output_backpressure();

        // Drain; the quiet tail catches any stray extra symbol.
        settle_idle();
        repeat (2 * FRAME_LEN) @(posedge clk);

        if (mismatches == 0 && symbols_due.size() == 0)
            $display("** time_code_frame_encoder: PASSED **");
        else
            $display("** time_code_frame_encoder: FAILED **");
        $finish;
    end

endmodule
